### design/owbm_pkg.sv
// shared types, constants and register map of the one-wire bus master
package owbm_pkg;

  // default structural values
  localparam int BitsPerByteDef   = 8;
  localparam int ReadTailTicksDef = 53;

  localparam int TickW = 10;
  localparam int FuncW = 3;
  localparam int ByteW = 8;
  localparam int BitIdxW = 3;
  localparam int CfgAddrW = 3;

  // command codes
  localparam logic [FuncW-1:0] FUNC_RESET      = 3'd0;
  localparam logic [FuncW-1:0] FUNC_WRITE_BIT  = 3'd1;
  localparam logic [FuncW-1:0] FUNC_READ_BIT   = 3'd2;
  localparam logic [FuncW-1:0] FUNC_WRITE_BYTE = 3'd3;
  localparam logic [FuncW-1:0] FUNC_READ_BYTE  = 3'd4;

  // register indexes
  localparam logic [CfgAddrW-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_RESET_REC     = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_WRITE_ONE_LOW = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_WRITE_ZERO_LOW = 3'd4;
  localparam logic [CfgAddrW-1:0] REG_WRITE_SLOT    = 3'd5;
  localparam logic [CfgAddrW-1:0] REG_READ_LOW      = 3'd6;
  localparam logic [CfgAddrW-1:0] REG_READ_SAMPLE   = 3'd7;

  // register reset values
  localparam logic [TickW-1:0] RESET_LOW_DEF      = 10'd480;
  localparam logic [TickW-1:0] PRESENCE_WAIT_DEF  = 10'd75;
  localparam logic [TickW-1:0] RESET_REC_DEF      = 10'd410;
  localparam logic [TickW-1:0] WRITE_ONE_LOW_DEF  = 10'd6;
  localparam logic [TickW-1:0] WRITE_ZERO_LOW_DEF = 10'd60;
  localparam logic [TickW-1:0] WRITE_SLOT_DEF     = 10'd70;
  localparam logic [TickW-1:0] READ_LOW_DEF       = 10'd3;
  localparam logic [TickW-1:0] READ_SAMPLE_DEF    = 10'd13;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RST_LOW  = 3'd1,
    PH_RST_WAIT = 3'd2,
    PH_RST_REC  = 3'd3,
    PH_WSLOT    = 3'd4,
    PH_RSLOT    = 3'd5,
    PH_RTAIL    = 3'd6
  } phase_e;

  typedef struct packed {
    logic [TickW-1:0] reset_low_ticks;
    logic [TickW-1:0] presence_wait_ticks;
    logic [TickW-1:0] reset_recovery_ticks;
    logic [TickW-1:0] write_one_low_ticks;
    logic [TickW-1:0] write_zero_low_ticks;
    logic [TickW-1:0] write_slot_ticks;
    logic [TickW-1:0] read_low_ticks;
    logic [TickW-1:0] read_sample_ticks;
  } cfg_t;

  typedef struct packed {
    logic             start_req;
    logic [FuncW-1:0] func;
    logic [ByteW-1:0] write_data;
    logic             line_level;
  } in_t;

  typedef struct packed {
    logic             drive_low;
    logic             busy_res;
    logic             done_res;
    logic [ByteW-1:0] read_data;
    logic             presence;
  } out_t;

endpackage

### design/owbm_cfg.sv
// timing register file of the one-wire bus master
module owbm_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [owbm_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [owbm_pkg::TickW-1:0]     cfg_wdata_i,
  output owbm_pkg::cfg_t                 cfg_o
);

  owbm_pkg::cfg_t cfg_q, cfg_d;

  // address decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        owbm_pkg::REG_RESET_LOW:      cfg_d.reset_low_ticks      = cfg_wdata_i;
        owbm_pkg::REG_PRESENCE_WAIT:  cfg_d.presence_wait_ticks  = cfg_wdata_i;
        owbm_pkg::REG_RESET_REC:      cfg_d.reset_recovery_ticks = cfg_wdata_i;
        owbm_pkg::REG_WRITE_ONE_LOW:  cfg_d.write_one_low_ticks  = cfg_wdata_i;
        owbm_pkg::REG_WRITE_ZERO_LOW: cfg_d.write_zero_low_ticks = cfg_wdata_i;
        owbm_pkg::REG_WRITE_SLOT:     cfg_d.write_slot_ticks     = cfg_wdata_i;
        owbm_pkg::REG_READ_LOW:       cfg_d.read_low_ticks       = cfg_wdata_i;
        owbm_pkg::REG_READ_SAMPLE:    cfg_d.read_sample_ticks    = cfg_wdata_i;
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  // registers with their reset timings
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_ticks      <= owbm_pkg::RESET_LOW_DEF;
      cfg_q.presence_wait_ticks  <= owbm_pkg::PRESENCE_WAIT_DEF;
      cfg_q.reset_recovery_ticks <= owbm_pkg::RESET_REC_DEF;
      cfg_q.write_one_low_ticks  <= owbm_pkg::WRITE_ONE_LOW_DEF;
      cfg_q.write_zero_low_ticks <= owbm_pkg::WRITE_ZERO_LOW_DEF;
      cfg_q.write_slot_ticks     <= owbm_pkg::WRITE_SLOT_DEF;
      cfg_q.read_low_ticks       <= owbm_pkg::READ_LOW_DEF;
      cfg_q.read_sample_ticks    <= owbm_pkg::READ_SAMPLE_DEF;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### design/owbm_seq.sv
// slot sequencer: advances the bus state by one tick per step
module owbm_seq #(
  parameter int BitsPerByte   = owbm_pkg::BitsPerByteDef,
  parameter int ReadTailTicks = owbm_pkg::ReadTailTicksDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  owbm_pkg::in_t   tick_i,
  input  owbm_pkg::cfg_t  cfg_i,
  output owbm_pkg::out_t  res_o
);

  localparam int BitCnt = (BitsPerByte < 1) ? 1 : ((BitsPerByte > 8) ? 8 : BitsPerByte);
  localparam logic [owbm_pkg::ByteW-1:0] DataMask = owbm_pkg::ByteW'((1 << BitCnt) - 1);
  localparam logic [owbm_pkg::TickW-1:0] TailTicks =
    (ReadTailTicks < 1) ? owbm_pkg::TickW'(1) : owbm_pkg::TickW'(ReadTailTicks);
  localparam logic [owbm_pkg::BitIdxW:0] BitCntW = (owbm_pkg::BitIdxW + 1)'(BitCnt);

  owbm_pkg::phase_e                  phase_q, phase_d;
  logic [owbm_pkg::FuncW-1:0]        op_q, op_d;
  logic [owbm_pkg::TickW-1:0]        tc_q, tc_d;
  logic [owbm_pkg::BitIdxW-1:0]      bi_q, bi_d;
  logic [owbm_pkg::ByteW-1:0]        sd_q, sd_d;
  logic                              pres_q, pres_d;

  logic [owbm_pkg::TickW-1:0] tc_inc;
  logic [owbm_pkg::TickW-1:0] slot_m1, samp, samp_m1, low_w, low_r;
  logic [owbm_pkg::TickW-1:0] rst_low, pres_wait, rst_rec;
  logic                       byte_op, more_bits, done;

  // one tick of the sequencer
  always_comb begin
    phase_d = phase_q;
    op_d    = op_q;
    tc_d    = tc_q;
    bi_d    = bi_q;
    sd_d    = sd_q;
    pres_d  = pres_q;
    done    = 1'b0;
    res_o   = '0;

    // command accepted only when idle and known
    if (phase_q == owbm_pkg::PH_IDLE && tick_i.start_req &&
        tick_i.func <= owbm_pkg::FUNC_READ_BYTE) begin
      op_d   = tick_i.func;
      tc_d   = '0;
      bi_d   = '0;
      pres_d = 1'b0;
      sd_d   = (tick_i.func == owbm_pkg::FUNC_WRITE_BIT ||
                tick_i.func == owbm_pkg::FUNC_WRITE_BYTE) ? tick_i.write_data : '0;
      if (tick_i.func == owbm_pkg::FUNC_RESET) begin
        phase_d = owbm_pkg::PH_RST_LOW;
      end else if (tick_i.func == owbm_pkg::FUNC_WRITE_BIT ||
                   tick_i.func == owbm_pkg::FUNC_WRITE_BYTE) begin
        phase_d = owbm_pkg::PH_WSLOT;
      end else begin
        phase_d = owbm_pkg::PH_RSLOT;
      end
    end
    res_o.busy_res = (phase_d != owbm_pkg::PH_IDLE);

    // clamped timings
    rst_low   = (cfg_i.reset_low_ticks == '0) ? owbm_pkg::TickW'(1) : cfg_i.reset_low_ticks;
    pres_wait = (cfg_i.presence_wait_ticks == '0) ? owbm_pkg::TickW'(1)
                                                  : cfg_i.presence_wait_ticks;
    rst_rec   = (cfg_i.reset_recovery_ticks == '0) ? owbm_pkg::TickW'(1)
                                                   : cfg_i.reset_recovery_ticks;
    slot_m1 = (cfg_i.write_slot_ticks < owbm_pkg::TickW'(2)) ? owbm_pkg::TickW'(1)
                                                             : cfg_i.write_slot_ticks - 1'b1;
    low_w = sd_d[bi_d] ? cfg_i.write_one_low_ticks : cfg_i.write_zero_low_ticks;
    if (low_w == '0) low_w = owbm_pkg::TickW'(1);
    if (low_w > slot_m1) low_w = slot_m1;
    samp = (cfg_i.read_sample_ticks < owbm_pkg::TickW'(2)) ? owbm_pkg::TickW'(2)
                                                           : cfg_i.read_sample_ticks;
    samp_m1 = samp - 1'b1;
    low_r = (cfg_i.read_low_ticks == '0) ? owbm_pkg::TickW'(1) : cfg_i.read_low_ticks;
    if (low_r > samp_m1) low_r = samp_m1;

    tc_inc    = tc_d + 1'b1;
    byte_op   = (op_d == owbm_pkg::FUNC_WRITE_BYTE || op_d == owbm_pkg::FUNC_READ_BYTE);
    more_bits = byte_op && ({1'b0, bi_d} + 1'b1 < BitCntW);

    unique case (phase_d)
      owbm_pkg::PH_IDLE: begin
      end
      owbm_pkg::PH_RST_LOW: begin
        res_o.drive_low = 1'b1;
        if (tc_inc >= rst_low) begin
          phase_d = owbm_pkg::PH_RST_WAIT;
          tc_d    = '0;
        end else begin
          tc_d = tc_inc;
        end
      end
      owbm_pkg::PH_RST_WAIT: begin
        if (tc_d >= pres_wait) begin
          pres_d  = ~tick_i.line_level;
          phase_d = owbm_pkg::PH_RST_REC;
          tc_d    = '0;
        end else begin
          tc_d = tc_inc;
        end
      end
      owbm_pkg::PH_RST_REC: begin
        tc_d = tc_inc;
        done = (tc_inc >= rst_rec);
      end
      owbm_pkg::PH_WSLOT: begin
        res_o.drive_low = (tc_d < low_w);
        if (tc_d >= slot_m1) begin
          if (more_bits) begin
            bi_d    = bi_d + 1'b1;
            tc_d    = '0;
            phase_d = owbm_pkg::PH_WSLOT;
          end else begin
            done = 1'b1;
          end
        end else begin
          tc_d = tc_inc;
        end
      end
      owbm_pkg::PH_RSLOT: begin
        res_o.drive_low = (tc_d < low_r);
        if (tc_d >= samp) begin
          if (tick_i.line_level) sd_d[bi_d] = 1'b1;
          phase_d = owbm_pkg::PH_RTAIL;
          tc_d    = '0;
        end else begin
          tc_d = tc_inc;
        end
      end
      owbm_pkg::PH_RTAIL: begin
        tc_d = tc_inc;
        if (tc_inc >= TailTicks) begin
          if (more_bits) begin
            bi_d    = bi_d + 1'b1;
            tc_d    = '0;
            phase_d = owbm_pkg::PH_RSLOT;
          end else begin
            done = 1'b1;
          end
        end
      end
      default: phase_d = owbm_pkg::PH_IDLE;
    endcase

    // final tick of a command
    if (done) begin
      if (op_d == owbm_pkg::FUNC_READ_BIT || op_d == owbm_pkg::FUNC_READ_BYTE) begin
        res_o.read_data = sd_d & DataMask;
      end
      if (op_d == owbm_pkg::FUNC_RESET) res_o.presence = pres_d;
      phase_d = owbm_pkg::PH_IDLE;
      tc_d    = '0;
    end
    res_o.done_res = done;
  end

  // sequencer state, advanced once per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= owbm_pkg::PH_IDLE;
      op_q    <= '0;
      tc_q    <= '0;
      bi_q    <= '0;
      sd_q    <= '0;
      pres_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      op_q    <= op_d;
      tc_q    <= tc_d;
      bi_q    <= bi_d;
      sd_q    <= sd_d;
      pres_q  <= pres_d;
    end
  end

endmodule

### design/one_wire_bus_master.sv
// top level of the one-wire bus master: tick register, sequencer, result register
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------
//  tick in  | in_valid_i / in_ready_o    | in_data_i  (owbm_pkg::in_t)
//  result   | out_valid_o / out_ready_i  | out_data_o (owbm_pkg::out_t)
//  config   | cfg_we_i, cfg_addr_i       | cfg_wdata_i (10-bit timing)
//
// one tick transaction in gives one result out, one per cycle while out_ready_i is high
// a result is offered once its tick has passed the tick register and then the sequencer
// step into the result register
// the sequencer state moves only when a tick leaves the tick register for the result register
// a stalled result holds both registers; input is still taken while the tick register is free
// reset clears the sequencer to idle and loads the default timings
module one_wire_bus_master #(
  parameter int BitsPerByte   = owbm_pkg::BitsPerByteDef,
  parameter int ReadTailTicks = owbm_pkg::ReadTailTicksDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  owbm_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output owbm_pkg::out_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [owbm_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [owbm_pkg::TickW-1:0]    cfg_wdata_i
);

  owbm_pkg::cfg_t cfg;
  owbm_pkg::out_t res;
  owbm_pkg::in_t  in_q;
  owbm_pkg::out_t out_q;
  logic           in_vld_q, out_vld_q;
  logic           step;

  owbm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // a tick steps the sequencer when the result register can take it
  assign step       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step;

  owbm_seq #(
    .BitsPerByte   (BitsPerByte),
    .ReadTailTicks (ReadTailTicks)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .tick_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // tick register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
